FILE: hw/rtl/bma_pkg.sv
// ----------------------------------------------------------------------------
// Buddy memory allocator package
// Shared constants, operation and status codes, and the status struct that
// the row search unit hands back to the sequencer.
// ----------------------------------------------------------------------------
package bma_pkg;

    // Default geometry of the managed region.
    localparam int REGION_BYTES    = 1024;
    localparam int MIN_BLOCK_BYTES = 8;
    localparam int TREE_LEVELS     = 8;

    // Largest number of occupancy bits held in one row of the occupancy store.
    localparam int ROW_UNITS_MAX = 8;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;

    // Result of examining one occupancy row.
    typedef struct packed {
        logic found;     // a free aligned block ends in this row
        logic grp_free;  // every row of the current group so far is empty
    } t_row_stat;

endpackage

FILE: hw/rtl/bma_row_unit.sv
// ----------------------------------------------------------------------------
// Buddy allocator row unit
// Examines one occupancy row per cycle: finds the lowest free aligned block
// inside the row, tracks emptiness across rows for blocks that span several
// rows, and builds the bit mask of the units of a block that fall in the row.
// ----------------------------------------------------------------------------
module bma_row_unit #(
    parameter int ROW_W  = 8,
    parameter int RIDX_W = 4,
    parameter int CNT_W  = 8
) (
    input  logic [ROW_W-1:0]     i_row_data,
    input  logic [RIDX_W-1:0]    i_row_idx,
    input  logic [CNT_W-1:0]     i_first,
    input  logic [CNT_W-1:0]     i_n,
    input  logic                 i_grp_free,
    output bma_pkg::t_row_stat   o_stat,
    output logic [CNT_W-1:0]     o_unit,
    output logic [ROW_W-1:0]     o_mask
);

    localparam int RB_W  = $clog2(ROW_W);
    localparam int SUM_W = CNT_W + 1;

    logic [CNT_W-1:0]  v_base;
    logic [SUM_W-1:0]  v_end;
    logic [SUM_W-1:0]  v_u;
    logic [ROW_W-1:0]  v_win;
    logic              v_hit;
    logic [CNT_W-1:0]  v_pos;
    logic              v_big;
    logic [RIDX_W-1:0] v_rmask;
    logic              v_gstart;
    logic              v_gend;
    logic              v_acc;

    always_comb begin
        v_base = CNT_W'(i_row_idx) << RB_W;
        v_end  = {1'b0, i_first} + {1'b0, i_n};
        v_win  = '0;
        v_u    = '0;
        v_hit  = 1'b0;
        v_pos  = '0;

        // Units of the block [first, first + n) that lie in this row.
        for (int j = 0; j < ROW_W; j++) begin
            v_u       = {1'b0, v_base + CNT_W'(j)};
            o_mask[j] = (v_u >= {1'b0, i_first}) && (v_u < v_end);
        end

        // Blocks no larger than a row: try every aligned offset, lowest first.
        for (int j = 0; j < ROW_W; j++) begin
            if (((CNT_W'(j) & (i_n - CNT_W'(1))) == '0) &&
                ((SUM_W'(j) + {1'b0, i_n}) <= SUM_W'(ROW_W))) begin
                for (int i = 0; i < ROW_W; i++) begin
                    v_win[i] = (i >= j) && (SUM_W'(i) < (SUM_W'(j) + {1'b0, i_n}));
                end
                if (!v_hit && ((i_row_data & v_win) == '0)) begin
                    v_hit = 1'b1;
                    v_pos = CNT_W'(j);
                end
            end
        end

        // Blocks larger than a row cover an aligned group of whole rows.
        v_big    = {1'b0, i_n} > SUM_W'(ROW_W);
        v_rmask  = RIDX_W'((i_n >> RB_W) - CNT_W'(1));
        v_gstart = (i_row_idx & v_rmask) == '0;
        v_gend   = (i_row_idx & v_rmask) == v_rmask;
        v_acc    = (v_gstart || i_grp_free) && (i_row_data == '0);

        o_stat.grp_free = v_acc;
        o_stat.found    = v_big ? (v_acc && v_gend) : v_hit;
        o_unit          = v_big ? (CNT_W'(i_row_idx & ~v_rmask) << RB_W) : (v_base + v_pos);
    end

endmodule

FILE: hw/rtl/buddy_memory_allocator.sv
// ----------------------------------------------------------------------------
// Buddy memory allocator
// Allocates and frees aligned power-of-two blocks of a byte region, keeping
// one occupancy bit per minimum-size unit.
// ----------------------------------------------------------------------------
// Usage: a request arrives on the input channel (i_in_valid / o_in_ready) as
// an opcode plus either an amount (allocate) or a block's first and last byte
// (free). Each request produces exactly one result transfer on the output
// channel (o_out_valid / i_out_ready): a status code and, for a successful
// allocate, the block's start address.
// The block works on one request at a time. An allocate is decoded, then
// the occupancy rows (16 rows by default) are scanned in order until a
// fitting block is found, then each row the block covers is marked, and
// finally the result is posted. A valid free skips the scan; a rejected
// request goes straight to posting its result.
// The row scan, one row per cycle through a single row unit, sets the rate.
// The result sits in an output register, so the next request is taken while
// an earlier result still waits; if the receiver stalls for longer, the
// sequencer holds the finished result until the output register frees.
// Reset (synchronous, active low) marks every unit free and empties the
// output register; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module buddy_memory_allocator #(
    parameter int REGION_BYTES    = bma_pkg::REGION_BYTES,
    parameter int MIN_BLOCK_BYTES = bma_pkg::MIN_BLOCK_BYTES,
    parameter int TREE_LEVELS     = bma_pkg::TREE_LEVELS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_opcode,
    input  logic [$clog2(REGION_BYTES):0]    i_amount,
    input  logic [$clog2(REGION_BYTES)-1:0]  i_block_start,
    input  logic [$clog2(REGION_BYTES)-1:0]  i_block_end,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [1:0]                       o_out_status,
    output logic [$clog2(REGION_BYTES)-1:0]  o_out_begin_address
);

    localparam int ADDR_W    = $clog2(REGION_BYTES);
    localparam int AMT_W     = ADDR_W + 1;
    localparam int MIN_W     = $clog2(MIN_BLOCK_BYTES);
    localparam int UNITS     = REGION_BYTES / MIN_BLOCK_BYTES;
    localparam int ROW_W     = (UNITS < bma_pkg::ROW_UNITS_MAX) ? UNITS
                                                                : bma_pkg::ROW_UNITS_MAX;
    localparam int ROWS      = UNITS / ROW_W;
    localparam int RB_W      = $clog2(ROW_W);
    localparam int RIDX_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W     = $clog2(UNITS) + 1;
    localparam int MAX_BLOCK = MIN_BLOCK_BYTES << (TREE_LEVELS - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_FILL = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    // Sequencer and request registers.
    t_state            r_state, n_state;
    bma_pkg::t_op      r_op, n_op;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [CNT_W-1:0]  r_first, n_first;
    logic [RIDX_W-1:0] r_row, n_row;
    logic              r_grp_free, n_grp_free;
    logic [1:0]        r_res_status, n_res_status;
    logic [ADDR_W-1:0] r_res_begin, n_res_begin;

    // Output register.
    logic              r_out_valid, n_out_valid;
    logic [1:0]        r_out_status, n_out_status;
    logic [ADDR_W-1:0] r_out_begin, n_out_begin;

    // Occupancy store, one row of ROW_W unit bits per entry.
    logic [ROW_W-1:0]  r_used [ROWS];
    logic [ROW_W-1:0]  row_data;
    logic [ROW_W-1:0]  n_row_data;
    logic              used_we;

    // Allocate decode.
    logic              fit_hit;
    logic [31:0]       fit_size;
    logic              alloc_ok;
    logic [CNT_W-1:0]  alloc_n;

    // Free decode.
    logic [AMT_W-1:0]  f_len;
    logic [AMT_W-1:0]  f_len_m1;
    logic              free_ok;
    logic [CNT_W-1:0]  free_n;
    logic [CNT_W-1:0]  free_first;

    // Row unit.
    bma_pkg::t_row_stat row_stat;
    logic [CNT_W-1:0]   row_unit;
    logic [ROW_W-1:0]   row_mask;
    logic [CNT_W:0]     fill_end;
    logic [RIDX_W-1:0]  fill_last_row;

    // Round the amount up to the smallest legal block size. Each level is an
    // independent compare against a constant; the lowest hit wins.
    always_comb begin
        fit_hit  = 1'b0;
        fit_size = '0;
        for (int k = 0; k < TREE_LEVELS; k++) begin
            if (!fit_hit && (32'(i_amount) <= (32'(MIN_BLOCK_BYTES) << k))) begin
                fit_hit  = 1'b1;
                fit_size = 32'(MIN_BLOCK_BYTES) << k;
            end
        end
        alloc_ok = fit_hit && (fit_size <= 32'(REGION_BYTES));
        alloc_n  = CNT_W'(fit_size >> MIN_W);
    end

    // A free must name an aligned block of a legal power-of-two length that
    // stays inside the region.
    always_comb begin
        f_len      = {1'b0, i_block_end} - {1'b0, i_block_start} + AMT_W'(1);
        f_len_m1   = f_len - AMT_W'(1);
        free_ok    = (i_block_end >= i_block_start) &&
                     ((f_len & f_len_m1) == '0) &&
                     (32'(f_len) >= 32'(MIN_BLOCK_BYTES)) &&
                     (32'(f_len) <= 32'(MAX_BLOCK)) &&
                     ((i_block_start & f_len_m1[ADDR_W-1:0]) == '0) &&
                     ((32'(i_block_start) + 32'(f_len)) <= 32'(REGION_BYTES));
        free_n     = CNT_W'(f_len >> MIN_W);
        free_first = CNT_W'(i_block_start >> MIN_W);
    end

    assign row_data = r_used[r_row];

    bma_row_unit #(
        .ROW_W  (ROW_W),
        .RIDX_W (RIDX_W),
        .CNT_W  (CNT_W)
    ) u_row_unit (
        .i_row_data (row_data),
        .i_row_idx  (r_row),
        .i_first    (r_first),
        .i_n        (r_n),
        .i_grp_free (r_grp_free),
        .o_stat     (row_stat),
        .o_unit     (row_unit),
        .o_mask     (row_mask)
    );

    // Last row touched by the block being marked or cleared.
    assign fill_end      = {1'b0, r_first} + {1'b0, r_n} - (CNT_W + 1)'(1);
    assign fill_last_row = RIDX_W'(fill_end >> RB_W);

    assign n_row_data = (r_op == bma_pkg::OP_ALLOC) ? (row_data | row_mask)
                                                    : (row_data & ~row_mask);

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_n          = r_n;
        n_first      = r_first;
        n_row        = r_row;
        n_grp_free   = r_grp_free;
        n_res_status = r_res_status;
        n_res_begin  = r_res_begin;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_begin  = r_out_begin;
        used_we      = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op = bma_pkg::t_op'(i_opcode);
                    if (i_opcode == bma_pkg::OP_ALLOC) begin
                        if (alloc_ok) begin
                            n_n        = alloc_n;
                            n_row      = '0;
                            n_grp_free = 1'b1;
                            n_state    = S_SCAN;
                        end else begin
                            n_res_status = bma_pkg::ST_NOSPACE;
                            n_res_begin  = '0;
                            n_state      = S_DONE;
                        end
                    end else begin
                        if (free_ok) begin
                            n_n     = free_n;
                            n_first = free_first;
                            n_row   = RIDX_W'(free_first >> RB_W);
                            n_state = S_FILL;
                        end else begin
                            n_res_status = bma_pkg::ST_BADFREE;
                            n_res_begin  = '0;
                            n_state      = S_DONE;
                        end
                    end
                end
            end
            S_SCAN: begin
                // Rows are visited in address order, so the first hit is the
                // lowest-address free block.
                n_grp_free = row_stat.grp_free;
                if (row_stat.found) begin
                    n_first = row_unit;
                    n_row   = RIDX_W'(row_unit >> RB_W);
                    n_state = S_FILL;
                end else if (r_row == RIDX_W'(ROWS - 1)) begin
                    n_res_status = bma_pkg::ST_NOSPACE;
                    n_res_begin  = '0;
                    n_state      = S_DONE;
                end else begin
                    n_row = RIDX_W'(r_row + 1'b1);
                end
            end
            S_FILL: begin
                used_we = 1'b1;
                if (r_row == fill_last_row) begin
                    n_res_status = bma_pkg::ST_OK;
                    n_res_begin  = (r_op == bma_pkg::OP_ALLOC) ? (ADDR_W'(r_first) << MIN_W)
                                                               : '0;
                    n_state      = S_DONE;
                end else begin
                    n_row = RIDX_W'(r_row + 1'b1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_begin  = r_res_begin;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_n          <= n_n;
        r_first      <= n_first;
        r_row        <= n_row;
        r_grp_free   <= n_grp_free;
        r_res_status <= n_res_status;
        r_res_begin  <= n_res_begin;
        r_out_status <= n_out_status;
        r_out_begin  <= n_out_begin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                r_used[r] <= '0;
            end
        end else if (used_we) begin
            r_used[r_row] <= n_row_data;
        end
    end

    assign o_in_ready          = (r_state == S_IDLE);
    assign o_out_valid         = r_out_valid;
    assign o_out_status        = r_out_status;
    assign o_out_begin_address = r_out_begin;

    // A taken request keeps the sequencer busy, so it is not ready in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("allocator ready in the cycle after taking a request");

    // Failed requests never report an address.
    a_fail_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_status != bma_pkg::ST_OK)) |-> (o_out_begin_address == '0))
        else $error("failed request reports a nonzero address");

    // Marking or clearing walks the rows strictly upward, one per cycle.
    a_fill_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FILL) && ($past(r_state) == S_FILL)) |->
            (r_row == RIDX_W'($past(r_row) + 1'b1)))
        else $error("fill pass skipped or repeated a row");

    // Only allocations search the occupancy store.
    a_scan_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_op == bma_pkg::OP_ALLOC))
        else $error("scan started for a free request");

endmodule
